// File: hdl/ffha_pkg.sv
package ffha_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_LARGEST = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_NEXT,
        ST_DONE
    } state_t;

    localparam int STATUS_OK   = 0;
    localparam int STATUS_FULL = 1;

    // bytes per heap word
    localparam int WORD_BYTES = 8;

endpackage

// File: hdl/ffha_if.sv
interface ffha_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] request_bytes;
    logic [11:0] block_address;

    modport source (output valid, command, request_bytes, block_address, input ready);
    modport sink (input valid, command, request_bytes, block_address, output ready);
endinterface

interface ffha_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [11:0] payload_address;
    logic [14:0] largest_bytes;

    modport source (output valid, status, payload_address, largest_bytes, input ready);
    modport sink (input valid, status, payload_address, largest_bytes, output ready);
endinterface

// File: hdl/first_fit_heap_allocator.sv
// First-fit heap allocator. Block headers (signed word sizes; positive free,
// negative allocated, zero end) live in one synchronous memory with a registered
// read. Each command other than CMD_NONE or a free of address zero walks the
// header chain from word 0, each header read going through read, evaluate, and
// advance or merge; a result can wait in its register until it is taken. A
// merge costs two reads (the neighbor and the grown block), a merge attempt on
// an allocated neighbor reads that neighbor twice, and a free of an early block
// is short. After reset and after each heap_words write a clearing pass over
// all HEAP_WORDS words zeroes the memory, with the head header at word 0, and
// accepts no item. One item is worked at a time; the result sits in an output
// register, freeing the input side once taken.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_WORDS = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [12:0]   cfg_wdata,
    ffha_in_if.sink       in_ch,
    ffha_out_if.source    out_ch
);
    localparam int AW = $clog2(HEAP_WORDS);
    // walk pointer, may pass the end; also holds the request size in words
    localparam int PW = (AW + 2 > 14) ? AW + 2 : 14;
    localparam int HW = AW + 2;             // signed header width
    localparam int WSH = $clog2(WORD_BYTES);

    // header memory
    logic signed [HW-1:0] mem [HEAP_WORDS];
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic signed [HW-1:0] mem_wdata, mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_raddr];
    end

    state_t state_reg, state_next;
    logic [PW-1:0] heap_len_reg, heap_len_next;
    logic [PW-1:0] clr_reg, clr_next;
    logic [PW-1:0] p_reg, p_next;
    logic signed [HW-1:0] h_reg, h_next;
    logic [1:0] cmd_reg, cmd_next;
    logic [PW-1:0] need_reg, need_next;
    logic [PW-1:0] target_reg, target_next;
    logic [PW-1:0] best_reg, best_next;
    logic [PW-1:0] best_free_reg, best_free_next;   // largest free payload in words
    logic merge_reg, merge_next;         // current read is the next block
    logic res_valid_reg, res_valid_next;
    logic res_status_reg, res_status_next;
    logic [11:0] res_paddr_reg, res_paddr_next;
    logic [14:0] res_largest_reg, res_largest_next;

    // clamped heap length from a register write
    function automatic logic [PW-1:0] clamp_len(input logic [12:0] v);
        logic [PW:0] w;
        w = (PW+1)'(v);
        if (w < (PW+1)'(3))
        begin
            return PW'(3);
        end
        if (w > (PW+1)'(HEAP_WORDS))
        begin
            return PW'(HEAP_WORDS);
        end
        return w[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] mag(input logic signed [HW-1:0] h);
        logic signed [HW-1:0] a;
        a = h[HW-1] ? -h : h;
        return PW'(a);
    endfunction

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            heap_len_reg  <= PW'(HEAP_WORDS);
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            heap_len_reg  <= heap_len_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg           <= p_next;
        h_reg           <= h_next;
        cmd_reg         <= cmd_next;
        need_reg        <= need_next;
        target_reg      <= target_next;
        best_reg        <= best_next;
        best_free_reg   <= best_free_next;
        merge_reg       <= merge_next;
        res_status_reg  <= res_status_next;
        res_paddr_reg   <= res_paddr_next;
        res_largest_reg <= res_largest_next;
    end

    assign in_ch.ready            = (state_reg == ST_IDLE) && !res_valid_reg;
    assign out_ch.valid           = res_valid_reg;
    assign out_ch.status          = res_status_reg;
    assign out_ch.payload_address = res_paddr_reg;
    assign out_ch.largest_bytes   = res_largest_reg;

    // walk sequencer
    always_comb
    begin
        logic [PW-1:0] sz, q, hp;
        logic [16:0]   rq;
        state_next       = state_reg;
        heap_len_next    = heap_len_reg;
        clr_next         = clr_reg;
        p_next           = p_reg;
        h_next           = h_reg;
        cmd_next         = cmd_reg;
        need_next        = need_reg;
        target_next      = target_reg;
        best_next        = best_reg;
        best_free_next   = best_free_reg;
        merge_next       = merge_reg;
        res_valid_next   = res_valid_reg;
        res_status_next  = res_status_reg;
        res_paddr_next   = res_paddr_reg;
        res_largest_next = res_largest_reg;
        mem_we           = 1'b0;
        mem_waddr        = p_reg[AW-1:0];
        mem_wdata        = '0;
        mem_raddr        = p_reg[AW-1:0];
        sz               = mag(h_reg);
        q                = p_reg + sz;
        hp               = PW'(h_reg);
        rq               = 17'(in_ch.request_bytes) + 17'(WORD_BYTES - 1);

        if (out_ch.valid && out_ch.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // zero one word a cycle, with the head header at word 0 and zeros as end marker
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AW-1:0];
                if (clr_reg == '0)
                begin
                    mem_wdata = HW'(heap_len_reg - 1'b1);
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == PW'(HEAP_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    cmd_next       = in_ch.command;
                    need_next      = PW'(rq >> WSH) + 1'b1;
                    target_next    = PW'(in_ch.block_address) - 1'b1;
                    best_next      = '0;
                    best_free_next = '0;
                    p_next         = '0;
                    merge_next     = 1'b0;
                    if (in_ch.command == CMD_NONE
                        || (in_ch.command == CMD_FREE && in_ch.block_address == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // address presented from p_reg
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                h_next = mem_rdata;
                if (p_reg >= heap_len_reg || mem_rdata == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (merge_reg)
                begin
                    // h_reg holds the following block, target_reg the free one
                    merge_next = 1'b0;
                    if (!h_reg[HW-1] && h_reg != '0)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = target_reg[AW-1:0];
                        mem_wdata = HW'(best_reg) + h_reg;
                        p_next    = target_reg;
                    end
                    else
                    begin
                        p_next = p_reg;
                        p_next = target_reg + best_reg;
                    end
                    best_next   = need_reg;
                    target_next = target_reg;
                    state_next  = ST_READ;
                end
                else
                begin
                    case (cmd_reg)
                        CMD_FREE:
                        begin
                            if (p_reg == target_reg)
                            begin
                                if (h_reg[HW-1])
                                begin
                                    mem_we    = 1'b1;
                                    mem_wdata = -h_reg;
                                end
                                state_next = ST_DONE;
                            end
                            else if (p_reg > target_reg)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                p_next     = q;
                                state_next = ST_READ;
                            end
                        end
                        CMD_ALLOC:
                        begin
                            if (h_reg[HW-1])
                            begin
                                p_next     = q;
                                state_next = ST_READ;
                            end
                            else if (hp >= need_reg)
                            begin
                                mem_we = 1'b1;
                                if (hp >= need_reg + 1'b1 && p_reg + need_reg < heap_len_reg)
                                begin
                                    mem_wdata = -HW'(need_reg);
                                    h_next    = HW'(hp - need_reg);
                                    p_next    = p_reg + need_reg;
                                    res_paddr_next = 12'(p_reg + 1'b1);
                                    best_next = '1;
                                    state_next = ST_DONE;
                                end
                                else
                                begin
                                    mem_wdata = -h_reg;
                                    res_paddr_next = 12'(p_reg + 1'b1);
                                    best_next = '0;
                                    state_next = ST_DONE;
                                end
                            end
                            else if (q < heap_len_reg)
                            begin
                                target_next = p_reg;
                                best_next   = hp;
                                p_next      = q;
                                merge_next  = 1'b1;
                                state_next  = ST_READ;
                            end
                            else
                            begin
                                p_next     = q;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            if (!h_reg[HW-1] && hp - 1'b1 > best_free_reg)
                            begin
                                best_free_next = hp - 1'b1;
                            end
                            if (!h_reg[HW-1] && q < heap_len_reg)
                            begin
                                target_next = p_reg;
                                best_next   = hp;
                                p_next      = q;
                                merge_next  = 1'b1;
                            end
                            else
                            begin
                                p_next = q;
                            end
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                // split remainder write, then post the result beat
                if (cmd_reg == CMD_ALLOC && best_reg == '1)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = h_reg;
                end
                if (!res_valid_reg)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = 1'(STATUS_OK);
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        if (res_paddr_reg == '0)
                        begin
                            res_status_next = 1'(STATUS_FULL);
                        end
                    end
                    else
                    begin
                        res_paddr_next = '0;
                    end
                    if (cmd_reg == CMD_LARGEST)
                    begin
                        res_largest_next = 15'(best_free_reg << WSH);
                    end
                    else
                    begin
                        res_largest_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // clear per-item result fields on accept
        if (state_reg == ST_IDLE && in_ch.valid && in_ch.ready)
        begin
            res_paddr_next   = '0;
            res_largest_next = '0;
        end

        // a heap size write restarts the clearing pass
        if (cfg_we)
        begin
            heap_len_next = clamp_len(cfg_wdata);
            clr_next      = '0;
            state_next    = ST_CLEAR;
        end
    end

    // no input beat outside idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |-> $past(state_reg) != ST_CLEAR || state_reg == ST_IDLE)
        else $error("beat accepted during clearing");
    // input ready only with a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.ready) |-> !res_valid_reg)
        else $error("input ready while result pending");
    // a failed allocate reports address zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status) |-> out_ch.payload_address == '0)
        else $error("failed allocate with address");
endmodule
